FILE: hw/rtl/free_list_block_allocator_macros.svh
// assertion macros used by the bound checker in flba_checker.sv
`ifndef FREE_LIST_BLOCK_ALLOCATOR_MACROS_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FLBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FLBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/flba_pkg.sv
`timescale 1ns / 1ps

package flba_pkg;

  // field widths
  localparam int ADDR_W      = 32;
  localparam int BYTES_W     = 16;
  localparam int COUNT_W     = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [BYTES_W-1:0] BYTES_RST = 16'd64;
  localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;

  typedef enum logic [IN_TUSER_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [OUT_TUSER_W-1:0] {
    ST_ALLOCATED  = 2'd0,
    ST_FREED      = 2'd1,
    ST_EXHAUSTED  = 2'd2,
    ST_EMPTY_FREE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_BYTES = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_e;

endpackage

FILE: hw/rtl/flba_ram.sv
`timescale 1ns / 1ps

module flba_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/free_list_block_allocator.sv
// channel   | dir | tdata                                 | tuser
// s_axis    | in  | [31:0] free_address                   | [0] opcode
// m_axis    | out | [31:0] block_address, [40:32] count   | [1:0] status
// cfg       | in  | write enable, index, data             | -
//
// One request occupies the read stage until it moves on, and the output register
// until taken; a new request enters while the read stage or the output
// register is free, so a request can enter before the result ahead of it is
// taken, but not while both hold a request.
// After reset every entry of the stack memory is swept to clear the
// written flags; s_axis_tready stays low during that sweep.
// A result passes the read stage and the output register before it can be taken.
`timescale 1ns / 1ps

module free_list_block_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [flba_pkg::CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [flba_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // request stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [flba_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [31:0] free_address
  input  logic [flba_pkg::IN_TUSER_W-1:0]        s_axis_tuser,  // [0] opcode
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [flba_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [31:0] block_address,
                                                                // [40:32] allocated_count
  output logic [flba_pkg::OUT_TUSER_W-1:0]       m_axis_tuser   // [1:0] status
);

  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int IW  = $clog2(MAX_BLOCKS + 1);
  localparam int CW  = (IW > flba_pkg::COUNT_W) ? IW : flba_pkg::COUNT_W;
  localparam int PW  = flba_pkg::BYTES_W + AW;
  localparam int MW  = flba_pkg::ADDR_W + 1;
  localparam int PADW = flba_pkg::OUT_TDATA_W - flba_pkg::COUNT_W - flba_pkg::ADDR_W;

  // configuration registers
  logic [flba_pkg::ADDR_W-1:0]  base_q;
  logic [flba_pkg::BYTES_W-1:0] bytes_q;
  logic [flba_pkg::COUNT_W-1:0] count_q;

  // clearing sweep
  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  // stack top
  logic [IW-1:0] top_q, top_d, top_dec;

  // read stage
  logic                         s1_valid_q;
  flba_pkg::status_e            s1_status_q;
  logic [flba_pkg::COUNT_W-1:0] s1_count_q;
  logic [PW-1:0]                s1_prod_q;

  // output register
  logic                         out_valid_q;
  flba_pkg::status_e            out_status_q;
  logic [flba_pkg::ADDR_W-1:0]  out_addr_q;
  logic [flba_pkg::COUNT_W-1:0] out_count_q;

  // request decode
  logic              in_acc, is_free, alloc_ok, free_ok, s1_move;
  flba_pkg::status_e status_d;
  logic [AW-1:0]     slot_alloc, slot_free;
  logic [PW-1:0]     prod_d;
  logic [flba_pkg::ADDR_W-1:0] addr_d;

  // memory port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= flba_pkg::BASE_RST;
      bytes_q <= flba_pkg::BYTES_RST;
      count_q <= flba_pkg::COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (flba_pkg::cfg_idx_e'(cfg_addr_i))
        flba_pkg::CFG_BASE:  base_q  <= cfg_wdata_i[flba_pkg::ADDR_W-1:0];
        flba_pkg::CFG_BYTES: bytes_q <= cfg_wdata_i[flba_pkg::BYTES_W-1:0];
        flba_pkg::CFG_COUNT: count_q <= cfg_wdata_i[flba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sweep after reset clears every written flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == AW'(MAX_BLOCKS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // handshake
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || !out_valid_q);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);

  // request decode and next top
  assign is_free    = (flba_pkg::op_e'(s_axis_tuser) == flba_pkg::OP_FREE);
  assign alloc_ok   = (CW'(top_q) < CW'(count_q)) && (top_q < IW'(MAX_BLOCKS));
  assign free_ok    = (top_q != '0);
  assign top_dec    = top_q - 1'b1;
  assign slot_alloc = top_q[AW-1:0];
  assign slot_free  = top_dec[AW-1:0];
  assign prod_d     = PW'(bytes_q) * PW'(slot_alloc);

  always_comb begin
    top_d    = top_q;
    status_d = flba_pkg::ST_EXHAUSTED;
    if (is_free) begin
      if (free_ok) begin
        status_d = flba_pkg::ST_FREED;
        top_d    = top_dec;
      end else begin
        status_d = flba_pkg::ST_EMPTY_FREE;
      end
    end else if (alloc_ok) begin
      status_d = flba_pkg::ST_ALLOCATED;
      top_d    = top_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else if (in_acc) begin
      top_q <= top_d;
    end
  end

  // stack memory: written flag in the top bit, then the address
  assign ram_we    = clr_busy_q || (in_acc && is_free && free_ok);
  assign ram_waddr = clr_busy_q ? clr_idx_q : slot_free;
  assign ram_wdata = clr_busy_q ? '0 : {1'b1, s_axis_tdata[flba_pkg::ADDR_W-1:0]};
  assign ram_re    = in_acc && !is_free && alloc_ok;

  flba_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_BLOCKS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_alloc),
    .rdata_o (ram_rdata)
  );

  // read stage: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage: payload, product of block size and slot
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_status_q <= status_d;
      s1_count_q  <= flba_pkg::COUNT_W'(top_d);
      s1_prod_q   <= prod_d;
    end
  end

  // pick stored or computed address
  always_comb begin
    addr_d = '0;
    if (s1_status_q == flba_pkg::ST_ALLOCATED) begin
      if (ram_rdata[MW-1]) begin
        addr_d = ram_rdata[flba_pkg::ADDR_W-1:0];
      end else begin
        addr_d = base_q + flba_pkg::ADDR_W'(s1_prod_q);
      end
    end
  end

  // output register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_status_q <= s1_status_q;
      out_addr_q   <= addr_d;
      out_count_q  <= s1_count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{PADW{1'b0}}, out_count_q, out_addr_q};

endmodule

FILE: hw/rtl/flba_checker.sv
`timescale 1ns / 1ps
`include "free_list_block_allocator_macros.svh"

module flba_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic [flba_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input logic [flba_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready
);

  // a stalled result holds its payload
  `FLBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

  // only a successful allocate carries an address
  `FLBA_ASSERT_NOW(a_addr_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != flba_pkg::ST_ALLOCATED),
    m_axis_tdata[31:0] == '0, "non-allocate result carries an address")

  // a free with nothing allocated leaves the count at zero
  `FLBA_ASSERT_NOW(a_empty_count, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == flba_pkg::ST_EMPTY_FREE),
    m_axis_tdata[40:32] == '0, "empty free with nonzero count")

endmodule

bind free_list_block_allocator flba_checker u_flba_checker (.*);

FILE: bench/free_list_block_allocator_checker.sv
`timescale 1ns / 1ps

module free_list_block_allocator_checker
  import flba_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_valid_i,
  input  logic                   s_ready_i,
  input  logic [IN_TDATA_W-1:0]  s_data_i,   // [31:0] free_address
  input  logic [IN_TUSER_W-1:0]  s_user_i,   // [0] opcode
  input  logic                   m_valid_i,
  input  logic                   m_ready_i,
  input  logic [OUT_TDATA_W-1:0] m_data_i,   // [31:0] block_address, [40:32] allocated_count
  input  logic [OUT_TUSER_W-1:0] m_user_i,   // [1:0] status
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    status_e              status;
    logic [ADDR_W-1:0]    addr;
    logic [COUNT_W-1:0]   count;
  } alloc_result_t;

  // results still owed by the block, oldest first
  alloc_result_t awaited_results[$];

  // shadow of the free stack and the registers
  logic [ADDR_W-1:0]  stack_mem [DEPTH];
  bit                 stack_written [DEPTH];
  int                 top_idx;
  logic [ADDR_W-1:0]  base_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [COUNT_W-1:0] count_r;

  int pending_q;
  int bad_q;

  assign pending_o    = pending_q;
  assign fail_count_o = bad_q;

  // apply one request to the shadow stack and return its result
  function automatic alloc_result_t serve_request(op_e op, logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int            limit;
    limit  = (int'(count_r) > DEPTH) ? DEPTH : int'(count_r);
    r.addr = '0;
    if (op == OP_ALLOC) begin
      if (top_idx >= limit) begin
        r.status = ST_EXHAUSTED;
      end else begin
        // a slot never freed into yields its position in the region
        if (stack_written[top_idx]) begin
          r.addr = stack_mem[top_idx];
        end else begin
          r.addr = base_r + 32'(bytes_r) * 32'(top_idx);
        end
        top_idx  = top_idx + 1;
        r.status = ST_ALLOCATED;
      end
    end else if (top_idx == 0) begin
      r.status = ST_EMPTY_FREE;
    end else begin
      top_idx                = top_idx - 1;
      stack_mem[top_idx]     = addr;
      stack_written[top_idx] = 1'b1;
      r.status               = ST_FREED;
    end
    r.count = COUNT_W'(top_idx);
    return r;
  endfunction

  // watch config writes and both streams; compare before predicting
  always @(posedge clk_i or negedge rst_ni) begin : track
    alloc_result_t want;
    alloc_result_t got;
    alloc_result_t next_res;
    int            pops;
    int            pushes;
    int            nbad;
    int            i;
    if (!rst_ni) begin
      for (i = 0; i < DEPTH; i++) stack_written[i] = 1'b0;
      top_idx = 0;
      base_r  = BASE_RST;
      bytes_r = BYTES_RST;
      count_r = COUNT_RST;
      awaited_results.delete();
      pending_q <= 0;
      bad_q     <= 0;
    end else begin
      pops   = 0;
      pushes = 0;
      nbad   = 0;

      // register write
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BASE:  base_r  = cfg_wdata_i[ADDR_W-1:0];
          CFG_BYTES: bytes_r = cfg_wdata_i[BYTES_W-1:0];
          CFG_COUNT: count_r = cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      // result transaction
      if (m_valid_i && m_ready_i) begin
        got.status = status_e'(m_user_i);
        got.addr   = m_data_i[ADDR_W-1:0];
        got.count  = m_data_i[ADDR_W +: COUNT_W];
        if (awaited_results.size() == 0) begin
          nbad = 1;
          if (bad_q < 10) begin
            $display("%0t: unexpected result status %0d addr %h count %0d",
                     $realtime, got.status, got.addr, got.count);
          end
        end else begin
          want = awaited_results.pop_front();
          pops = 1;
          if (got.status !== want.status || got.addr !== want.addr ||
              got.count !== want.count) begin
            nbad = 1;
            if (bad_q < 10) begin
              $display("%0t: mismatch (exp/act) status %0d/%0d addr %h/%h count %0d/%0d",
                       $realtime, want.status, got.status, want.addr, got.addr,
                       want.count, got.count);
            end
          end
        end
      end

      // request transaction
      if (s_valid_i && s_ready_i) begin
        next_res        = serve_request(op_e'(s_user_i), s_data_i[ADDR_W-1:0]);
        awaited_results = {awaited_results, next_res};
        pushes          = 1;
      end

      pending_q <= pending_q + pushes - pops;
      bad_q     <= bad_q + nbad;
    end
  end

endmodule

FILE: bench/free_list_block_allocator_tb.sv
`timescale 1ns / 1ps

module free_list_block_allocator_tb;
  import flba_pkg::*;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [31:0] free_address
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // [0] opcode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [31:0] block_address, [40:32] allocated_count
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // [1:0] status

  logic calm_q = 1'b0;
  int   fail_count;
  int   pending;

  free_list_block_allocator #(
    .MAX_BLOCKS(256)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  free_list_block_allocator_checker #(
    .DEPTH(256)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // result side stalls about one cycle in ten unless calm
  always @(posedge clk_i) begin
    m_axis_tready <= calm_q || ($urandom_range(0, 99) >= 10);
  end

  // one register write, block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // one request transaction, with an occasional gap ahead of it
  task automatic send_req(input op_e op, input logic [ADDR_W-1:0] addr);
    if (!calm_q && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // one random phase under a fixed register setting
  task automatic run_phase(input int n, input int alloc_pct, input logic [ADDR_W-1:0] base,
                           input logic [BYTES_W-1:0] bytes, input logic [COUNT_W-1:0] count);
    logic [ADDR_W-1:0] a;
    write_reg(CFG_BASE, base);
    write_reg(CFG_BYTES, {16'b0, bytes});
    write_reg(CFG_COUNT, {23'b0, count});
    for (int k = 0; k < n; k++) begin
      // now and then let the block run dry mid-phase
      if ($urandom_range(0, 99) == 0) drain();
      // mix foreign addresses with ones inside the region
      if ($urandom_range(0, 1) == 1) a = $urandom;
      else a = base + 32'(bytes) * 32'($urandom_range(0, 255));
      send_req(($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE, a);
    end
    drain();
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: free on empty, allocate fresh slots, free back, reuse
    send_req(OP_FREE,  32'h1234_5678);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'hFFFF_FFFF);
    send_req(OP_FREE,  32'hFFFF_FFFF);
    send_req(OP_FREE,  32'h0000_0000);
    send_req(OP_FREE,  32'hDEAD_BEEF);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    drain();

    // count lowered below the top index
    write_reg(CFG_COUNT, 32'd1);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_FREE,  32'h5555_AAAA);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_FREE,  32'hAAAA_5555);
    send_req(OP_FREE,  32'h0000_0001);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    drain();

    // zero blocks: allocates exhausted, frees still work
    write_reg(CFG_COUNT, 32'd0);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_FREE,  32'h8000_0000);
    send_req(OP_ALLOC, 32'h0);
    drain();

    // largest base and block size, count above depth, address wraps
    write_reg(CFG_BASE,  32'hFFFF_FFFF);
    write_reg(CFG_BYTES, 32'h0000_FFFF);
    write_reg(CFG_COUNT, 32'h0000_01FF);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    drain();

    // zero block size: fresh slots all yield the base
    write_reg(CFG_BYTES, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_ALLOC, 32'h0);
    drain();

    // random phases
    run_phase(320, 95, $urandom, 16'($urandom_range(1, 65535)), 9'd256);
    run_phase(200, 60, 32'h0, 16'd1, 9'($urandom_range(1, 16)));
    run_phase(200, 50, 32'hFFFF_FFFF, 16'hFFFF, 9'd300);
    run_phase(150, 30, $urandom, 16'd0, 9'd0);
    run_phase(200, 55, $urandom, 16'($urandom_range(1, 65535)), 9'd2);
    run_phase(250, 50, $urandom, 16'($urandom), 9'($urandom_range(1, 256)));
    calm_q <= 1'b1;
    run_phase(250, 50, $urandom, 16'($urandom_range(1, 65535)), 9'd256);
    calm_q <= 1'b0;
    run_phase(200, 50, $urandom, 16'($urandom_range(1, 65535)), 9'd1);

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/flba_pkg.sv
hw/rtl/flba_ram.sv
hw/rtl/free_list_block_allocator.sv
hw/rtl/flba_checker.sv
bench/free_list_block_allocator_checker.sv
bench/free_list_block_allocator_tb.sv
